// File: rtl/led_strip_pattern_generator_defines.svh
// Assertion macros for the LED strip pattern generator checker.
// No dependencies; taken in by the checker file only.
`ifndef LED_STRIP_PATTERN_GENERATOR_DEFINES_SVH
`define LED_STRIP_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lsp_pkg.sv
// Shared types, widths and codes for the LED strip pattern generator.
// No dependencies; compiled first.
package lsp_pkg;

    localparam int IDX_W      = 6;
    localparam int COL_W      = 8;
    localparam int GRB_W      = 24;
    localparam int MODE_W     = 3;
    localparam int GRP_W      = 3;
    localparam int STEP_W     = 3;
    localparam int GAP_W      = 3;
    localparam int GSZ_W      = 6;
    localparam int PHASE_W    = 5;
    localparam int ACC_W      = 8;
    localparam int LIMIT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam int DEF_LED_COUNT = 43;

    localparam logic [GRP_W-1:0]   FLOW_GROUPS     = 3'd5;
    localparam logic [STEP_W-1:0]  RST_ARROW_STEP  = 3'd2;
    localparam logic [GAP_W-1:0]   RST_ARROW_SPACE = 3'd1;
    localparam logic [GSZ_W-1:0]   RST_GROUP_SIZE  = 6'd9;
    localparam logic [PHASE_W-1:0] RST_FLOW_PHASE  = 5'd1;

    // frame modes
    localparam logic [MODE_W-1:0] MODE_MAIN_FULL  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAIN_STAGE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAIN_FLOW  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SIDE_FULL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SIDE_STAGE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ARROW_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARROW_SPACE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_LIFT,
        ST_ALIGN,
        ST_WRAP,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ALU_SUB_PERIOD,
        ALU_SUB_PHASE,
        ALU_ADD_PERIOD
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [ACC_W-1:0]   acc;
        logic [PHASE_W-1:0] period;
        logic [PHASE_W-1:0] phase;
    } t_alu_ctl;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             neg;
    } t_alu_res;

endpackage

// File: rtl/lsp_if.sv
// Handshake channel interfaces: frame requests, LED items, configuration writes.
// Depends on lsp_pkg.
interface lsp_frame_if import lsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic [GRP_W-1:0]  groups;

    modport source (output valid, mode, red, green, blue, groups, input ready);
    modport sink   (input valid, mode, red, green, blue, groups, output ready);
endinterface

interface lsp_led_if import lsp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] led_index;
    logic [GRB_W-1:0] outer_grb;
    logic [GRB_W-1:0] middle_grb;
    logic [GRB_W-1:0] inner_grb;
    logic [GRB_W-1:0] side_grb;
    logic             main_updated;
    logic             side_updated;
    logic             last;

    modport source (output valid, led_index, outer_grb, middle_grb, inner_grb, side_grb,
                    main_updated, side_updated, last, input ready);
    modport sink   (input valid, led_index, outer_grb, middle_grb, inner_grb, side_grb,
                    main_updated, side_updated, last, output ready);
endinterface

interface lsp_cfg_if import lsp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/lsp_mod_unit.sv
// Shared add/subtract unit with sign flag, used by the sequencer for all
// modulo reduction steps. Depends on lsp_pkg.
module lsp_mod_unit import lsp_pkg::*; (
    input  t_alu_ctl i_ctl,
    output t_alu_res o_res
);

    logic [ACC_W-1:0] w_opnd;
    logic [ACC_W-1:0] w_sum;

    always_comb begin
        case (i_ctl.op)
            ALU_SUB_PERIOD: w_opnd = ~ACC_W'(i_ctl.period) + ACC_W'(1);
            ALU_SUB_PHASE:  w_opnd = ~ACC_W'(i_ctl.phase) + ACC_W'(1);
            ALU_ADD_PERIOD: w_opnd = ACC_W'(i_ctl.period);
            default:        w_opnd = '0;
        endcase
        w_sum = i_ctl.acc + w_opnd;
    end

    // operands stay below 2^(ACC_W-1), so the top bit is the sign
    assign o_res.sum = w_sum;
    assign o_res.neg = w_sum[ACC_W-1];

endmodule

// File: rtl/led_strip_pattern_generator.sv
// LED strip pattern generator, top level: sequencer, registers, output stage.
// Depends on lsp_pkg, lsp_if and lsp_mod_unit.
//
// Usage
//  - i_frame takes one frame request (mode, colour, group count). Each
//    request in modes 0..4 returns LED_COUNT items on o_led, index 0 first,
//    the final one flagged with last. Modes 5..7 are swallowed: no items.
//  - i_cfg writes arrow_step (0), arrow spacing (1), group_size (2); other
//    indexes are dropped. Write only while no frame is in flight.
//  - In full and stage modes a taken request moves the sequencer to its emit
//    state, and each item is then registered in the output register before it
//    shows on o_led. Flow mode first reduces the phase and the start position
//    mod the period on the shared subtractor (phase, lift, align, wrap states).
//  - Throughput: one item per cycle once emitting, while o_led is ready;
//    i_frame.ready is high only between frames. The next request may be taken
//    while the final item of the previous frame still waits in the output register.
//  - A stalled receiver simply holds the output register; nothing is lost.
//  - Reset (synchronous, active low) restores the register defaults, sets
//    the flow phase to one and drops any frame in progress.
module led_strip_pattern_generator import lsp_pkg::*; #(
    parameter int LED_COUNT = DEF_LED_COUNT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lsp_cfg_if.sink      i_cfg,
    lsp_frame_if.sink    i_frame,
    lsp_led_if.source    o_led
);

    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(LED_COUNT - 1);
    localparam logic [ACC_W-1:0]   LED_LAST  = ACC_W'(LED_COUNT - 1);
    localparam logic [LIMIT_W-1:0] LED_LIMIT = LIMIT_W'(LED_COUNT);

    // configuration registers
    logic [STEP_W-1:0]  r_step;
    logic [GAP_W-1:0]   r_gap;
    logic [GSZ_W-1:0]   r_gsize;

    // sequencer state
    t_state             r_state, n_state;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [ACC_W-1:0]   r_acc,   n_acc;
    logic [PHASE_W-1:0] r_pos,   n_pos;
    logic [IDX_W-1:0]   r_idx,   n_idx;

    // frame snapshot
    logic [MODE_W-1:0]  r_mode,  n_mode;
    logic [GRB_W-1:0]   r_colour, n_colour;
    logic [ACC_W-1:0]   r_first_lit, n_first_lit;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_idx,   n_out_idx;
    logic [GRB_W-1:0]   r_out_outer, n_out_outer;
    logic [GRB_W-1:0]   r_out_middle, n_out_middle;
    logic [GRB_W-1:0]   r_out_inner, n_out_inner;
    logic [GRB_W-1:0]   r_out_side,  n_out_side;
    logic               r_out_main,  n_out_main;
    logic               r_out_sidef, n_out_sidef;
    logic               r_out_last,  n_out_last;

    logic [PHASE_W-1:0] w_period;
    logic [PHASE_W-1:0] w_step1, w_step2, w_step3;
    logic [GRP_W-1:0]   w_mult;
    logic [LIMIT_W-1:0] w_limit;
    logic [ACC_W-1:0]   w_first;
    logic               w_frame_acc;
    logic               w_slot;
    logic               w_lit;
    logic [GRB_W-1:0]   w_outer, w_middle, w_inner, w_side;
    t_alu_ctl           w_alu_ctl;
    t_alu_res           w_alu_res;

    // period = 3*step + gap, at most 28
    assign w_step1  = PHASE_W'(r_step);
    assign w_step2  = w_step1 << 1;
    assign w_step3  = w_step2 + w_step1;
    assign w_period = w_step3 + PHASE_W'(r_gap);

    // lit threshold: LEDs at or beyond first_lit belong to the tail
    assign w_mult  = (i_frame.mode == MODE_MAIN_FLOW) ? FLOW_GROUPS : i_frame.groups;
    assign w_limit = LIMIT_W'(w_mult) * LIMIT_W'(r_gsize);
    assign w_first = (w_limit >= LED_LIMIT) ? '0 : ACC_W'(LED_LIMIT - w_limit);

    assign i_frame.ready = (r_state == ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign w_frame_acc   = i_frame.valid && i_frame.ready;
    assign w_slot        = !r_out_valid || o_led.ready;

    lsp_mod_unit u_lsp_mod_unit (
        .i_ctl (w_alu_ctl),
        .o_res (w_alu_res)
    );

    // per-LED colour decode
    always_comb begin
        w_lit    = (ACC_W'(r_idx) >= r_first_lit);
        w_outer  = '0;
        w_middle = '0;
        w_inner  = '0;
        w_side   = '0;
        case (r_mode)
            MODE_MAIN_FULL: begin
                w_outer  = r_colour;
                w_middle = r_colour;
                w_inner  = r_colour;
            end
            MODE_MAIN_STAGE: begin
                if (w_lit) begin
                    w_outer  = r_colour;
                    w_middle = r_colour;
                    w_inner  = r_colour;
                end
            end
            MODE_MAIN_FLOW: begin
                // windows: inner [0,step), middle [step,2step), outer [2step,3step)
                if (w_lit && (w_period != '0)) begin
                    if (r_pos < w_step1)
                        w_inner = r_colour;
                    else if (r_pos < w_step2)
                        w_middle = r_colour;
                    else if (r_pos < w_step3)
                        w_outer = r_colour;
                end
            end
            MODE_SIDE_FULL: begin
                w_side = r_colour;
            end
            MODE_SIDE_STAGE: begin
                if (w_lit)
                    w_side = r_colour;
            end
            default: begin
                w_side = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_mode       = r_mode;
        n_colour     = r_colour;
        n_first_lit  = r_first_lit;
        n_out_valid  = r_out_valid && !o_led.ready;
        n_out_idx    = r_out_idx;
        n_out_outer  = r_out_outer;
        n_out_middle = r_out_middle;
        n_out_inner  = r_out_inner;
        n_out_side   = r_out_side;
        n_out_main   = r_out_main;
        n_out_sidef  = r_out_sidef;
        n_out_last   = r_out_last;

        w_alu_ctl.acc    = r_acc;
        w_alu_ctl.period = w_period;
        w_alu_ctl.phase  = r_phase;
        w_alu_ctl.op     = ALU_SUB_PERIOD;

        case (r_state)
            ST_IDLE: begin
                if (w_frame_acc && (i_frame.mode <= MODE_SIDE_STAGE)) begin
                    n_mode      = i_frame.mode;
                    n_colour    = {i_frame.green, i_frame.red, i_frame.blue};
                    n_first_lit = w_first;
                    n_idx       = '0;
                    if (i_frame.mode == MODE_MAIN_FLOW) begin
                        if (w_period == '0) begin
                            // no period: phase collapses, nothing lit
                            n_phase = '0;
                            n_state = ST_EMIT;
                        end else begin
                            n_acc   = ACC_W'(r_phase) + ACC_W'(1);
                            n_state = ST_PHASE;
                        end
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_PHASE: begin
                // phase = (phase + 1) mod period, by repeated subtraction
                w_alu_ctl.op = ALU_SUB_PERIOD;
                if (w_alu_res.neg) begin
                    n_phase = r_acc[PHASE_W-1:0];
                    n_acc   = LED_LAST;
                    n_state = ST_LIFT;
                end else begin
                    n_acc = w_alu_res.sum;
                end
            end
            ST_LIFT: begin
                // keep (N-1) + period - phase non-negative
                w_alu_ctl.op = ALU_ADD_PERIOD;
                n_acc        = w_alu_res.sum;
                n_state      = ST_ALIGN;
            end
            ST_ALIGN: begin
                w_alu_ctl.op = ALU_SUB_PHASE;
                n_acc        = w_alu_res.sum;
                n_state      = ST_WRAP;
            end
            ST_WRAP: begin
                // window position of LED 0, mod period
                w_alu_ctl.op = ALU_SUB_PERIOD;
                if (w_alu_res.neg) begin
                    n_pos   = r_acc[PHASE_W-1:0];
                    n_state = ST_EMIT;
                end else begin
                    n_acc = w_alu_res.sum;
                end
            end
            ST_EMIT: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_idx;
                    n_out_outer  = w_outer;
                    n_out_middle = w_middle;
                    n_out_inner  = w_inner;
                    n_out_side   = w_side;
                    n_out_main   = (r_mode <= MODE_MAIN_FLOW);
                    n_out_sidef  = (r_mode >= MODE_SIDE_FULL);
                    n_out_last   = (r_idx == LAST_IDX);
                    n_idx        = r_idx + IDX_W'(1);
                    // mirrored index falls by one, so the position steps back
                    n_pos = (r_pos == '0) ? (w_period - PHASE_W'(1))
                                          : (r_pos - PHASE_W'(1));
                    if (r_idx == LAST_IDX)
                        n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= RST_FLOW_PHASE;
            r_out_valid <= 1'b0;
            r_step      <= RST_ARROW_STEP;
            r_gap       <= RST_ARROW_SPACE;
            r_gsize     <= RST_GROUP_SIZE;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_ARROW_STEP:  r_step  <= i_cfg.data[STEP_W-1:0];
                    CFG_ARROW_SPACE: r_gap   <= i_cfg.data[GAP_W-1:0];
                    CFG_GROUP_SIZE:  r_gsize <= i_cfg.data[GSZ_W-1:0];
                    default:         r_step  <= r_step;
                endcase
            end
        end
    end

    // payload and datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_mode       <= n_mode;
        r_colour     <= n_colour;
        r_first_lit  <= n_first_lit;
        r_out_idx    <= n_out_idx;
        r_out_outer  <= n_out_outer;
        r_out_middle <= n_out_middle;
        r_out_inner  <= n_out_inner;
        r_out_side   <= n_out_side;
        r_out_main   <= n_out_main;
        r_out_sidef  <= n_out_sidef;
        r_out_last   <= n_out_last;
    end

    assign o_led.valid        = r_out_valid;
    assign o_led.led_index    = r_out_idx;
    assign o_led.outer_grb    = r_out_outer;
    assign o_led.middle_grb   = r_out_middle;
    assign o_led.inner_grb    = r_out_inner;
    assign o_led.side_grb     = r_out_side;
    assign o_led.main_updated = r_out_main;
    assign o_led.side_updated = r_out_sidef;
    assign o_led.last         = r_out_last;

endmodule

// File: rtl/lsp_checker.sv
// Port-level checker for the LED strip pattern generator, bound to the top.
// Depends on lsp_pkg and led_strip_pattern_generator_defines.svh.
`include "led_strip_pattern_generator_defines.svh"

module lsp_checker import lsp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_frame_ready,
    input logic             i_led_valid,
    input logic             i_led_ready,
    input logic [IDX_W-1:0] i_led_index,
    input logic [GRB_W-1:0] i_outer_grb,
    input logic             i_main_updated,
    input logic             i_side_updated,
    input logic             i_last
);

    // a stalled item holds still
    `LSP_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_led_valid && !i_led_ready, i_led_valid && $stable(i_led_index) && $stable(i_outer_grb), "stalled led item changed")

    // within a frame items follow back to back in index order
    `LSP_ASSERT_NXT(a_next_led, i_clk, i_rst_n, i_led_valid && i_led_ready && !i_last, i_led_valid && (i_led_index == $past(i_led_index) + 6'd1), "led items not contiguous")

    // a new frame is taken only once the old one is down to its final item
    `LSP_ASSERT_IMP(a_ready_tail, i_clk, i_rst_n, i_frame_ready && i_led_valid, i_last, "frame ready with a frame still emitting")

    // every item belongs to exactly one strip group
    `LSP_ASSERT_IMP(a_one_group, i_clk, i_rst_n, i_led_valid, i_main_updated != i_side_updated, "update flags inconsistent")

endmodule

bind led_strip_pattern_generator lsp_checker u_lsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_frame_ready  (i_frame.ready),
    .i_led_valid    (o_led.valid),
    .i_led_ready    (o_led.ready),
    .i_led_index    (o_led.led_index),
    .i_outer_grb    (o_led.outer_grb),
    .i_main_updated (o_led.main_updated),
    .i_side_updated (o_led.side_updated),
    .i_last         (o_led.last)
);

// File: bench/tb_led_strip_pattern_generator.sv
// Self-checking bench for led_strip_pattern_generator: random and directed frame requests.
// Predicts every LED item from its own copy of the registers and flow phase.
// Depends on lsp_pkg and lsp_if.
`timescale 1ns / 100ps

module tb_led_strip_pattern_generator;
    import lsp_pkg::*;

    localparam int LEDS           = DEF_LED_COUNT;
    localparam int PHASE_ITEMS    = 14;        // counted requests per register setting
    localparam int N_FIXED        = 5;
    localparam int N_RANDOM       = 3;
    localparam int QUIET_CYCLES   = 200;       // longer than the worst flow set-up
    localparam int RX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int MAX_REPORTS    = 40;

    // modes past side stage are swallowed by the block
    localparam logic [MODE_W-1:0]    MODE_BAD_LO = MODE_SIDE_STAGE + 3'd1;
    localparam logic [MODE_W-1:0]    MODE_BAD_HI = '1;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [COL_W-1:0]  red;
        logic [COL_W-1:0]  green;
        logic [COL_W-1:0]  blue;
        logic [GRP_W-1:0]  groups;
    } t_frame;

    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        logic [GRB_W-1:0] outer_grb;
        logic [GRB_W-1:0] middle_grb;
        logic [GRB_W-1:0] inner_grb;
        logic [GRB_W-1:0] side_grb;
        logic             main_updated;
        logic             side_updated;
        logic             last;
    } t_led_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lsp_cfg_if   cfg_if();
    lsp_frame_if frm_if();
    lsp_led_if   led_if();

    led_strip_pattern_generator #(.LED_COUNT(LEDS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_frame (frm_if),
        .o_led   (led_if)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's registers and flow phase, as after reset.
    int step_q  = int'(RST_ARROW_STEP);
    int gap_q   = int'(RST_ARROW_SPACE);
    int gsize_q = int'(RST_GROUP_SIZE);
    int phase_q = int'(RST_FLOW_PHASE);

    t_frame    frame_queue[$];     // requests not yet offered
    t_led_word led_expect[$];      // LED items predicted, oldest first
    t_frame    cur_frame;          // request currently on the bus
    bit        offering = 1'b0;
    bit        idle_on  = 1'b1;    // random gaps on both sides when set
    int        tx_gap   = 0;
    int        rx_gap   = 0;
    bit        rx_hold_req  = 1'b0;
    int        rx_hold_left = 0;

    int cycle_count   = 0;
    int mismatches    = 0;
    int frames_taken  = 0;
    int frames_silent = 0;
    int leds_checked  = 0;
    int settings_used = 0;

    // Register data per fixed setting; high bits beyond each field are set on
    // purpose in places and must be dropped. Covers period three, the widest
    // period, zero group size, and a zero period (step and gap both zero).
    logic [CFG_DATA_W-1:0] step_tab [N_FIXED] = '{6'd1, 6'd4, 6'h3F, 6'd0, 6'd8};
    logic [CFG_DATA_W-1:0] gap_tab  [N_FIXED] = '{6'd0, 6'd7, 6'h3F, 6'd0, 6'd5};
    logic [CFG_DATA_W-1:0] gsize_tab[N_FIXED] = '{6'd1, 6'd0, 6'd63, 6'd9, 6'd5};

    // ------------------------------------------------------------------
    // Predictor: one frame request in modes 0..4 -> LED_COUNT expected items.
    // ------------------------------------------------------------------
    function automatic void predict_frame(input t_frame f);
        int               period;
        int               limit;
        int               rev;
        int               pos;
        bit               lit;
        logic [GRB_W-1:0] colour;
        t_led_word        w;
        if (f.mode > MODE_SIDE_STAGE) begin
            frames_silent++;
            return;
        end
        colour = {f.green, f.red, f.blue};
        period = 3 * step_q + gap_q;
        // flow phase steps before the frame is built
        if (f.mode == MODE_MAIN_FLOW)
            phase_q = (period == 0) ? 0 : ((phase_q + 1) % period);
        // lit tail length, computed wide so large products saturate to all LEDs
        if (f.mode == MODE_MAIN_FLOW)
            limit = int'(FLOW_GROUPS) * gsize_q;
        else
            limit = int'(f.groups) * gsize_q;
        for (int i = 0; i < LEDS; i++) begin
            w = '0;
            lit = (i + limit >= LEDS);
            case (f.mode)
                MODE_MAIN_FULL: begin
                    w.outer_grb  = colour;
                    w.middle_grb = colour;
                    w.inner_grb  = colour;
                end
                MODE_MAIN_STAGE: begin
                    if (lit) begin
                        w.outer_grb  = colour;
                        w.middle_grb = colour;
                        w.inner_grb  = colour;
                    end
                end
                MODE_MAIN_FLOW: begin
                    // arrows run on the mirrored index: inner, middle, outer windows
                    if (period != 0 && lit) begin
                        rev = LEDS - 1 - i;
                        pos = ((rev % period) + period - (phase_q % period)) % period;
                        if (pos < step_q)
                            w.inner_grb = colour;
                        else if (pos < 2 * step_q)
                            w.middle_grb = colour;
                        else if (pos < 3 * step_q)
                            w.outer_grb = colour;
                    end
                end
                MODE_SIDE_FULL: begin
                    w.side_grb = colour;
                end
                default: begin
                    if (lit)
                        w.side_grb = colour;
                end
            endcase
            w.led_index    = i[IDX_W-1:0];
            w.main_updated = (f.mode <= MODE_MAIN_FLOW);
            w.side_updated = (f.mode >= MODE_SIDE_FULL);
            w.last         = (i == LEDS - 1);
            led_expect.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Compare the LED item on the bus with the oldest prediction.
    task automatic check_led();
        t_led_word want;
        if (led_expect.size() == 0) begin
            report_mismatch($sformatf("LED item index %0d with nothing pending",
                                      led_if.led_index));
            return;
        end
        want = led_expect.pop_front();
        leds_checked++;
        if (led_if.led_index !== want.led_index)
            report_mismatch($sformatf("led_index got %0d want %0d",
                                      led_if.led_index, want.led_index));
        if (led_if.outer_grb !== want.outer_grb)
            report_mismatch($sformatf("outer_grb at %0d got %h want %h",
                                      want.led_index, led_if.outer_grb, want.outer_grb));
        if (led_if.middle_grb !== want.middle_grb)
            report_mismatch($sformatf("middle_grb at %0d got %h want %h",
                                      want.led_index, led_if.middle_grb, want.middle_grb));
        if (led_if.inner_grb !== want.inner_grb)
            report_mismatch($sformatf("inner_grb at %0d got %h want %h",
                                      want.led_index, led_if.inner_grb, want.inner_grb));
        if (led_if.side_grb !== want.side_grb)
            report_mismatch($sformatf("side_grb at %0d got %h want %h",
                                      want.led_index, led_if.side_grb, want.side_grb));
        if (led_if.main_updated !== want.main_updated)
            report_mismatch($sformatf("main_updated at %0d got %b want %b",
                                      want.led_index, led_if.main_updated,
                                      want.main_updated));
        if (led_if.side_updated !== want.side_updated)
            report_mismatch($sformatf("side_updated at %0d got %b want %b",
                                      want.led_index, led_if.side_updated,
                                      want.side_updated));
        if (led_if.last !== want.last)
            report_mismatch($sformatf("last at %0d got %b want %b",
                                      want.led_index, led_if.last, want.last));
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COL_W-1:0] rand_colour();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COL_W'($urandom_range(0, (1 << COL_W) - 1));
        endcase
    endfunction

    // Flow-heavy mix so the phase counter wraps under most settings.
    function automatic t_frame rand_frame();
        t_frame f;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            f.mode = MODE_MAIN_FULL;
        else if (pick < 25)
            f.mode = MODE_MAIN_STAGE;
        else if (pick < 60)
            f.mode = MODE_MAIN_FLOW;
        else if (pick < 68)
            f.mode = MODE_SIDE_FULL;
        else if (pick < 85)
            f.mode = MODE_SIDE_STAGE;
        else
            f.mode = MODE_W'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
        f.red    = rand_colour();
        f.green  = rand_colour();
        f.blue   = rand_colour();
        f.groups = GRP_W'($urandom_range(0, (1 << GRP_W) - 1));
        return f;
    endfunction

    task automatic add_frame(input logic [MODE_W-1:0] mode, input logic [COL_W-1:0] red,
                             input logic [COL_W-1:0] green, input logic [COL_W-1:0] blue,
                             input logic [GRP_W-1:0] groups);
        frame_queue.push_back('{mode, red, green, blue, groups});
    endtask

    // Queue random requests until 'count' of them produce output.
    task automatic queue_random(input int count);
        t_frame f;
        int     counted;
        counted = 0;
        while (counted < count) begin
            f = rand_frame();
            frame_queue.push_back(f);
            if (f.mode <= MODE_SIDE_STAGE)
                counted++;
        end
    endtask

    // Wait for every request to go and every LED item to come back, then
    // give a swallowed request time to clear before the next register write.
    task automatic settle(input int quiet);
        while (frame_queue.size() != 0 || offering || led_expect.size() != 0)
            @(posedge i_clk);
        repeat (quiet) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        case (idx)
            CFG_ARROW_STEP:  step_q  = int'(val[STEP_W-1:0]);
            CFG_ARROW_SPACE: gap_q   = int'(val[GAP_W-1:0]);
            CFG_GROUP_SIZE:  gsize_q = int'(val[GSZ_W-1:0]);
            default: ;      // unused index is dropped by the block
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Request driver: fed from frame_queue, changes on the falling edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!offering) begin
            if (tx_gap > 0) begin
                tx_gap--;
                frm_if.valid <= 1'b0;
            end else if (frame_queue.size() != 0) begin
                cur_frame = frame_queue.pop_front();
                offering  = 1'b1;
                frm_if.valid  <= 1'b1;
                frm_if.mode   <= cur_frame.mode;
                frm_if.red    <= cur_frame.red;
                frm_if.green  <= cur_frame.green;
                frm_if.blue   <= cur_frame.blue;
                frm_if.groups <= cur_frame.groups;
                // gap, if any, opens once this request is taken
                if (idle_on && $urandom_range(0, 2) == 0)
                    tx_gap = pick_gap();
            end else begin
                frm_if.valid <= 1'b0;
            end
        end
    end

    // Receiver ready: a long hold when asked, otherwise random stalls.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            led_if.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            led_if.ready <= 1'b0;
        end else begin
            led_if.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                rx_gap = pick_gap();
        end
    end

    // Long receiver hold, counted here so the sender keeps offering meanwhile.
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes requests into the predictor, checks LED items,
    // and stops a run that hangs.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run stopped at cycle %0d with %0d LED items outstanding",
                     cycle_count, led_expect.size());
            $display("tb_led_strip_pattern_generator failed");
            $finish;
        end else if (i_rst_n) begin
            if (frm_if.valid && frm_if.ready) begin
                predict_frame(cur_frame);
                frames_taken++;
                offering = 1'b0;
            end
            if (led_if.valid && led_if.ready)
                check_led();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] data;
        frame_queue.delete();
        i_rst_n       = 1'b0;
        frm_if.valid  = 1'b0;
        frm_if.mode   = MODE_MAIN_FULL;
        frm_if.red    = '0;
        frm_if.green  = '0;
        frm_if.blue   = '0;
        frm_if.groups = '0;
        led_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_ARROW_STEP;
        cfg_if.data   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: step 2, gap 1, group size 9, period 7.
        // Receiver holds off at once, so the block fills and stalls its input.
        settings_used++;
        rx_hold_req = 1'b1;
        add_frame(MODE_MAIN_FULL,  8'hFF, 8'hFF, 8'hFF, 3'd0);
        add_frame(MODE_MAIN_FULL,  8'h00, 8'h00, 8'h00, 3'd7);
        add_frame(MODE_MAIN_STAGE, 8'hAA, 8'h55, 8'hAA, 3'd0);   // nothing lit
        add_frame(MODE_MAIN_STAGE, 8'h55, 8'hAA, 8'h55, 3'd1);
        add_frame(MODE_MAIN_STAGE, 8'h12, 8'h34, 8'h56, 3'd4);
        add_frame(MODE_MAIN_STAGE, 8'h80, 8'h01, 8'hFE, 3'd5);   // limit past the end
        add_frame(MODE_MAIN_STAGE, 8'h7F, 8'hFF, 8'h00, 3'd7);
        add_frame(MODE_MAIN_FLOW,  8'hFF, 8'h00, 8'h00, 3'd0);
        add_frame(MODE_MAIN_FLOW,  8'h00, 8'hFF, 8'h00, 3'd7);
        add_frame(MODE_MAIN_FLOW,  8'h00, 8'h00, 8'hFF, 3'd3);
        // swallowed modes between flow frames: phase must not move
        add_frame(MODE_BAD_LO,           8'hFF, 8'hFF, 8'hFF, 3'd7);
        add_frame(MODE_BAD_LO + 3'd1,    8'h00, 8'h00, 8'h00, 3'd0);
        add_frame(MODE_BAD_HI,           8'hAA, 8'hAA, 8'hAA, 3'd5);
        add_frame(MODE_MAIN_FLOW,  8'h0F, 8'hF0, 8'h3C, 3'd1);
        add_frame(MODE_SIDE_FULL,  8'h55, 8'hAA, 8'h55, 3'd0);
        add_frame(MODE_SIDE_STAGE, 8'hC3, 8'h3C, 8'h99, 3'd0);
        add_frame(MODE_SIDE_STAGE, 8'h01, 8'h02, 8'h04, 3'd3);
        add_frame(MODE_SIDE_STAGE, 8'hFF, 8'hFF, 8'hFF, 3'd5);
        add_frame(MODE_SIDE_STAGE, 8'h66, 8'h99, 8'h66, 3'd7);
        // three more flow frames: phase wraps round period 7
        add_frame(MODE_MAIN_FLOW,  8'hFF, 8'hFF, 8'hFF, 3'd6);
        add_frame(MODE_MAIN_FLOW,  8'h81, 8'h42, 8'h24, 3'd2);
        add_frame(MODE_MAIN_FLOW,  8'h18, 8'hE7, 8'h5A, 3'd4);
        queue_random(PHASE_ITEMS);
        settle(QUIET_CYCLES);

        // Register sweep: fixed corner settings, then random ones.
        for (int s = 0; s < N_FIXED + N_RANDOM; s++) begin
            idle_on = (s % 3) != 1;             // every third setting runs flat out
            if (s < N_FIXED) begin
                write_reg(CFG_ARROW_STEP,  step_tab[s]);
                write_reg(CFG_ARROW_SPACE, gap_tab[s]);
                write_reg(CFG_GROUP_SIZE,  gsize_tab[s]);
            end else begin
                data = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
                data[STEP_W-1:0] = STEP_W'($urandom_range(1, 4));
                write_reg(CFG_ARROW_STEP, data);
                write_reg(CFG_ARROW_SPACE,
                          CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
                write_reg(CFG_GROUP_SIZE,
                          CFG_DATA_W'($urandom_range(1, (1 << GSZ_W) - 1)));
            end
            if (s == 0)
                write_reg(CFG_UNUSED, '1);      // must leave all registers alone
            settings_used++;
            if (s == 2) begin
                // sender stops halfway until the block has delivered everything
                queue_random(PHASE_ITEMS / 2);
                settle(0);
                queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                queue_random(PHASE_ITEMS);
            end
            settle(QUIET_CYCLES);
        end

        $display("%0d frame requests taken (%0d in unused modes), %0d register settings",
                 frames_taken, frames_silent, settings_used);
        $display("%0d LED items checked in %0d cycles, %0d mismatches",
                 leds_checked, cycle_count, mismatches);
        if (mismatches == 0 && led_expect.size() == 0)
            $display("tb_led_strip_pattern_generator passed");
        else
            $display("tb_led_strip_pattern_generator failed");
        $finish;
    end

endmodule
